>>> hw/rtl/foes_pkg.sv
// Shared constants and types for the face owner element search block.
// No dependencies; foes_ctrl and face_owner_element_search import this package.
`default_nettype none

package foes_pkg;

  // Fixed port widths of the command channel.
  localparam int MODE_W      = 2;
  localparam int NODE_PORT_W = 12;
  localparam int SLOT_PORT_W = 4;
  localparam int ELEM_W      = 16;

  // Command codes carried on the mode port.
  localparam logic [MODE_W-1:0] MODE_ENTRY = 2'd0;
  localparam logic [MODE_W-1:0] MODE_COUNT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FACE  = 2'd2;

  // Status handed from the search sequencer to the top level.
  typedef struct packed {
    logic busy;
    logic done;
    logic found;
  } srch_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/foes_ram.sv
// Generic single-port synchronous RAM with a registered read.
// Depends on nothing; used for both adjacency stores.
`default_nettype none

module foes_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/foes_ctrl.sv
// Search sequencer: walks the adjacency lists of the stored face nodes
// through the two RAMs, one read at a time. Imports foes_pkg.
`default_nettype none

module foes_ctrl
  import foes_pkg::*;
#(
  parameter int NODE_COUNT     = 4096,
  parameter int SLOTS_PER_NODE = 16,
  parameter int MAX_FACE_NODES = 4,
  localparam int NODE_W  = $clog2(NODE_COUNT),
  localparam int CNT_W   = $clog2(SLOTS_PER_NODE + 1),
  localparam int FCNT_W  = $clog2(MAX_FACE_NODES + 1),
  localparam int TADDR_W = $clog2(NODE_COUNT * SLOTS_PER_NODE)
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  go,
  input  wire logic [FCNT_W-1:0]                     face_count,
  input  wire logic [MAX_FACE_NODES-1:0][NODE_W-1:0] face_idx,
  input  wire logic [MAX_FACE_NODES-1:0]             face_ok,
  input  wire logic [CNT_W-1:0]                      cnt_rdata,
  input  wire logic [ELEM_W-1:0]                     tbl_rdata,
  output logic      [NODE_W-1:0]                     cnt_addr,
  output logic      [TADDR_W-1:0]                    tbl_addr,
  output logic      [ELEM_W-1:0]                     element,
  output srch_status_t                               status
);

  localparam int JW = (MAX_FACE_NODES > 1) ? $clog2(MAX_FACE_NODES) : 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LAUNCH,
    S_L0_REQ,
    S_L0_GOT,
    S_C_REQ,
    S_C_GOT,
    S_LJ_REQ,
    S_LJ_GOT,
    S_S_REQ,
    S_S_GOT
  } state_t;

  state_t              state, state_next;
  logic [FCNT_W-1:0]   n, n_next;
  logic [FCNT_W-1:0]   j, j_next;
  logic [CNT_W-1:0]    len0, len0_next;
  logic [CNT_W-1:0]    lenj, lenj_next;
  logic [CNT_W-1:0]    i, i_next;
  logic [CNT_W-1:0]    k, k_next;
  logic [ELEM_W-1:0]   cand, cand_next;
  logic [NODE_W-1:0]   cnt_addr_next;
  logic [TADDR_W-1:0]  tbl_addr_next;
  logic                done, done_next;
  logic                found, found_next;
  logic [ELEM_W-1:0]   element_next;

  logic                do_start;
  logic                do_fail;
  logic [FCNT_W-1:0]   start_j;
  logic [CNT_W-1:0]    i_inc;
  logic [CNT_W-1:0]    k_inc;
  logic [FCNT_W-1:0]   j_inc;
  logic [NODE_W-1:0]   cur_node;
  logic [NODE_W-1:0]   start_node;

  function automatic logic [TADDR_W-1:0] entry_addr(input logic [NODE_W-1:0] nd,
                                                    input logic [CNT_W-1:0]  sl);
    logic [31:0] a;
    a = 32'(nd) * SLOTS_PER_NODE + 32'(sl);
    return a[TADDR_W-1:0];
  endfunction

  assign i_inc      = i + 1'b1;
  assign k_inc      = k + 1'b1;
  assign j_inc      = j + 1'b1;
  assign cur_node   = face_idx[j[JW-1:0]];
  assign start_node = face_idx[start_j[JW-1:0]];

  always_comb begin
    state_next    = state;
    n_next        = n;
    j_next        = j;
    len0_next     = len0;
    lenj_next     = lenj;
    i_next        = i;
    k_next        = k;
    cand_next     = cand;
    cnt_addr_next = cnt_addr;
    tbl_addr_next = tbl_addr;
    done_next     = 1'b0;
    found_next    = found;
    element_next  = element;
    do_start      = 1'b0;
    do_fail       = 1'b0;
    start_j       = j_inc;

    case (state)
      S_IDLE: begin
        if (go) begin
          n_next     = face_count;
          state_next = S_LAUNCH;
        end
      end
      S_LAUNCH: begin
        if (!face_ok[0]) begin
          done_next    = 1'b1;
          found_next   = 1'b0;
          element_next = '0;
          state_next   = S_IDLE;
        end else begin
          cnt_addr_next = face_idx[0];
          state_next    = S_L0_REQ;
        end
      end
      S_L0_REQ: state_next = S_L0_GOT;
      S_L0_GOT: begin
        len0_next = cnt_rdata;
        i_next    = '0;
        if (cnt_rdata == '0) begin
          done_next    = 1'b1;
          found_next   = 1'b0;
          element_next = '0;
          state_next   = S_IDLE;
        end else begin
          tbl_addr_next = entry_addr(face_idx[0], '0);
          state_next    = S_C_REQ;
        end
      end
      S_C_REQ: state_next = S_C_GOT;
      S_C_GOT: begin
        cand_next = tbl_rdata;
        if (n == FCNT_W'(1)) begin
          done_next    = 1'b1;
          found_next   = 1'b1;
          element_next = tbl_rdata;
          state_next   = S_IDLE;
        end else begin
          do_start = 1'b1;
          start_j  = FCNT_W'(1);
        end
      end
      S_LJ_REQ: state_next = S_LJ_GOT;
      S_LJ_GOT: begin
        lenj_next = cnt_rdata;
        k_next    = '0;
        if (cnt_rdata == '0) begin
          do_fail = 1'b1;
        end else begin
          tbl_addr_next = entry_addr(cur_node, '0);
          state_next    = S_S_REQ;
        end
      end
      S_S_REQ: state_next = S_S_GOT;
      S_S_GOT: begin
        if (tbl_rdata == cand) begin
          // This node lists the candidate; move on or report it.
          if (j_inc == n) begin
            done_next    = 1'b1;
            found_next   = 1'b1;
            element_next = cand;
            state_next   = S_IDLE;
          end else begin
            do_start = 1'b1;
            start_j  = j_inc;
          end
        end else if (k_inc == lenj) begin
          do_fail = 1'b1;
        end else begin
          k_next        = k_inc;
          tbl_addr_next = entry_addr(cur_node, k_inc);
          state_next    = S_S_REQ;
        end
      end
      default: state_next = S_IDLE;
    endcase

    // Begin scanning the list of face node start_j, or drop the candidate
    // at once when that node lies outside the table.
    if (do_start) begin
      if (face_ok[start_j[JW-1:0]]) begin
        j_next        = start_j;
        cnt_addr_next = start_node;
        state_next    = S_LJ_REQ;
      end else begin
        do_fail = 1'b1;
      end
    end

    // The current candidate misses a face node: try the next one, or end the search unfound after the last.
    if (do_fail) begin
      if (i_inc == len0) begin
        done_next    = 1'b1;
        found_next   = 1'b0;
        element_next = '0;
        state_next   = S_IDLE;
      end else begin
        i_next        = i_inc;
        tbl_addr_next = entry_addr(face_idx[0], i_inc);
        state_next    = S_C_REQ;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      done    <= 1'b0;
      found   <= 1'b0;
      element <= '0;
    end else begin
      state   <= state_next;
      done    <= done_next;
      found   <= found_next;
      element <= element_next;
    end
    n        <= n_next;
    j        <= j_next;
    len0     <= len0_next;
    lenj     <= lenj_next;
    i        <= i_next;
    k        <= k_next;
    cand     <= cand_next;
    cnt_addr <= cnt_addr_next;
    tbl_addr <= tbl_addr_next;
  end

  assign status.busy  = (state != S_IDLE);
  assign status.done  = done;
  assign status.found = found;

endmodule

`default_nettype wire

>>> hw/rtl/face_owner_element_search.sv
// Top level of the face owner element search block: command decode, face
// node capture and the two adjacency RAMs. Depends on foes_pkg, foes_ram
// and foes_ctrl.
//
// Usage: one command channel (start/busy) carries mode, node, slot, value
// and last_node; a transaction is taken at a clock edge with start high and
// busy low. Entry writes (mode 0) and count writes (mode 1) give no
// result. Face node commands (mode 2) are stored, up to MAX_FACE_NODES
// of them; the one with last_node set starts a search and raises busy
// from the next cycle.
// The search reads the node lists one RAM word at a time.
// The result (element, found) is shown for exactly one cycle with done
// high, in the cycle in which busy falls; the receiver cannot stall it.
// Reset clears the face node count and the sequencer; RAM contents are
// undefined until written.
`default_nettype none

module face_owner_element_search
  import foes_pkg::*;
#(
  parameter int NODE_COUNT       = 4096,
  parameter int SLOTS_PER_NODE   = 16,
  parameter int MAX_FACE_NODES   = 4,
  parameter int ELEMENT_ID_RANGE = 65536
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [MODE_W-1:0]      mode,
  input  wire logic [NODE_PORT_W-1:0] node,
  input  wire logic [SLOT_PORT_W-1:0] slot,
  input  wire logic [ELEM_W-1:0]      value,
  input  wire logic                   last_node,
  output logic                        done,
  output logic      [ELEM_W-1:0]      element,
  output logic                        found
);

  localparam int NODE_W  = $clog2(NODE_COUNT);
  localparam int CNT_W   = $clog2(SLOTS_PER_NODE + 1);
  localparam int FCNT_W  = $clog2(MAX_FACE_NODES + 1);
  localparam int JW      = (MAX_FACE_NODES > 1) ? $clog2(MAX_FACE_NODES) : 1;
  localparam int TDEPTH  = NODE_COUNT * SLOTS_PER_NODE;
  localparam int TADDR_W = $clog2(TDEPTH);

  srch_status_t status;

  logic                                  accept;
  logic [31:0]                           node_ext;
  logic [31:0]                           slot_ext;
  logic [31:0]                           value_ext;
  logic [NODE_W-1:0]                     node_idx;
  logic                                  node_ok;
  logic                                  tbl_we;
  logic                                  cnt_we;
  logic [TADDR_W-1:0]                    tbl_waddr;
  logic [TADDR_W-1:0]                    tbl_addr;
  logic [TADDR_W-1:0]                    srch_tbl_addr;
  logic [NODE_W-1:0]                     cnt_addr;
  logic [NODE_W-1:0]                     srch_cnt_addr;
  logic [CNT_W-1:0]                      cnt_wdata;
  logic [CNT_W-1:0]                      cnt_rdata;
  logic [ELEM_W-1:0]                     tbl_rdata;
  logic                                  face_cmd;
  logic                                  go;
  logic [FCNT_W-1:0]                     face_node_count;
  logic [FCNT_W-1:0]                     face_total;
  logic                                  face_room;
  logic [MAX_FACE_NODES-1:0][NODE_W-1:0] face_idx;
  logic [MAX_FACE_NODES-1:0]             face_ok;
  logic [31:0]                           waddr_full;

  assign accept    = start && !busy;
  assign node_ext  = 32'(node);
  assign slot_ext  = 32'(slot);
  assign value_ext = 32'(value);
  assign node_idx  = node_ext[NODE_W-1:0];
  assign node_ok   = node_ext < NODE_COUNT;

  assign waddr_full = node_ext * SLOTS_PER_NODE + slot_ext;
  assign tbl_waddr  = waddr_full[TADDR_W-1:0];

  assign tbl_we = accept && (mode == MODE_ENTRY) && node_ok &&
                  (slot_ext < SLOTS_PER_NODE) && (value_ext < ELEMENT_ID_RANGE);
  assign cnt_we = accept && (mode == MODE_COUNT) && node_ok;

  // Counts above the slot capacity saturate.
  assign cnt_wdata = (value_ext > SLOTS_PER_NODE) ? CNT_W'(SLOTS_PER_NODE)
                                                  : value_ext[CNT_W-1:0];

  // Writes happen only while the sequencer is idle, so the RAM port is
  // simply handed over to the search while busy.
  assign tbl_addr = status.busy ? srch_tbl_addr : tbl_waddr;
  assign cnt_addr = status.busy ? srch_cnt_addr : node_idx;

  assign face_cmd   = accept && (mode == MODE_FACE);
  assign face_room  = face_node_count < FCNT_W'(MAX_FACE_NODES);
  assign face_total = face_room ? face_node_count + 1'b1 : face_node_count;
  assign go         = face_cmd && last_node;

  always_ff @(posedge clk) begin
    if (rst) begin
      face_node_count <= '0;
    end else if (face_cmd) begin
      if (last_node) begin
        face_node_count <= '0;
      end else if (face_room) begin
        face_node_count <= face_node_count + 1'b1;
      end
    end
    if (face_cmd && face_room) begin
      face_idx[face_node_count[JW-1:0]] <= node_idx;
      face_ok[face_node_count[JW-1:0]]  <= node_ok;
    end
  end

  foes_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (TDEPTH)
  ) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .addr  (tbl_addr),
    .wdata (value),
    .rdata (tbl_rdata)
  );

  foes_ram #(
    .WIDTH (CNT_W),
    .DEPTH (NODE_COUNT)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .addr  (cnt_addr),
    .wdata (cnt_wdata),
    .rdata (cnt_rdata)
  );

  foes_ctrl #(
    .NODE_COUNT     (NODE_COUNT),
    .SLOTS_PER_NODE (SLOTS_PER_NODE),
    .MAX_FACE_NODES (MAX_FACE_NODES)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .go         (go),
    .face_count (face_total),
    .face_idx   (face_idx),
    .face_ok    (face_ok),
    .cnt_rdata  (cnt_rdata),
    .tbl_rdata  (tbl_rdata),
    .cnt_addr   (srch_cnt_addr),
    .tbl_addr   (srch_tbl_addr),
    .element    (element),
    .status     (status)
  );

  assign busy  = status.busy;
  assign done  = status.done;
  assign found = status.found;

  // A result only ever closes a search.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a preceding search");

  a_zero_when_missing: assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> (element == '0))
    else $error("element not zero on a failed search");

  a_no_write_in_search: assert property (@(posedge clk) disable iff (rst)
    (tbl_we || cnt_we) |-> !status.busy)
    else $error("table write during a search");

  a_last_starts_search: assert property (@(posedge clk) disable iff (rst)
    (accept && (mode == MODE_FACE) && last_node) |=> busy)
    else $error("last face node did not start a search");

endmodule

`default_nettype wire

>>> tb/face_owner_element_search_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for face_owner_element_search: drives table loads and
// faces over the start/busy channel and checks every (element, found) result.
// Depends on foes_pkg and the face_owner_element_search RTL.

module face_owner_element_search_tb;
  import foes_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int SLOTS       = 16;
  localparam int FACE_MAX    = 4;
  localparam int TAIL_CYCLES = 2000;

  typedef struct {
    logic [MODE_W-1:0]      mode;
    logic [NODE_PORT_W-1:0] node;
    logic [SLOT_PORT_W-1:0] slot;
    logic [ELEM_W-1:0]      value;
    logic                   last;
    bit                     drain;  // wait for all owners before this transaction
  } cmd_t;

  typedef struct {
    logic [ELEM_W-1:0] element;
    logic              found;
  } owner_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  logic [MODE_W-1:0]      mode = '0;
  logic [NODE_PORT_W-1:0] node = '0;
  logic [SLOT_PORT_W-1:0] slot = '0;
  logic [ELEM_W-1:0]      value = '0;
  logic                   last_node = 1'b0;
  logic                   done;
  logic [ELEM_W-1:0]      element;
  logic                   found;

  face_owner_element_search uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .mode      (mode),
    .node      (node),
    .slot      (slot),
    .value     (value),
    .last_node (last_node),
    .done      (done),
    .element   (element),
    .found     (found)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  cmd_t   cmd_q[$];
  owner_t owner_q[$];
  cmd_t   cur_cmd;
  int     n_accepted = 0;
  bit     failed = 1'b0;

  // Predicted contents of the block.
  logic [ELEM_W-1:0]      adj_tab [0:65535];
  logic [4:0]             adj_len [0:4095];
  logic [NODE_PORT_W-1:0] face_buf [0:FACE_MAX-1];
  int                     face_fill = 0;

  // Stimulus bookkeeping.
  bit                     in_pool [0:4095];
  logic [NODE_PORT_W-1:0] pool[$];
  logic [ELEM_W-1:0]      elem_pool [0:7];
  int                     n_items = 0;
  int                     n_faces = 0;

  function automatic void find_owner(output logic [ELEM_W-1:0] elem, output logic hit);
    int i, j, k, hits;
    logic [ELEM_W-1:0]      cand;
    logic [NODE_PORT_W-1:0] nd;
    elem = '0;
    hit  = 1'b0;
    if (face_fill == 0) return;
    for (i = 0; i < adj_len[face_buf[0]]; i++) begin
      cand = adj_tab[{face_buf[0], i[3:0]}];
      hits = 1;
      for (j = 1; j < face_fill; j++) begin
        nd = face_buf[j];
        for (k = 0; k < adj_len[nd]; k++) begin
          if (adj_tab[{nd, k[3:0]}] == cand) begin
            hits++;
            break;
          end
        end
      end
      if (hits == face_fill) begin
        elem = cand;
        hit  = 1'b1;
        return;
      end
    end
  endfunction

  function automatic void apply_cmd(input cmd_t c);
    owner_t o;
    case (c.mode)
      MODE_ENTRY: adj_tab[{c.node, c.slot}] = c.value;
      MODE_COUNT: adj_len[c.node] = (c.value > SLOTS) ? 5'(SLOTS) : c.value[4:0];
      MODE_FACE: begin
        if (face_fill < FACE_MAX) begin
          face_buf[face_fill] = c.node;
          face_fill++;
        end
        if (c.last) begin
          find_owner(o.element, o.found);
          owner_q.push_back(o);
          face_fill = 0;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic push_cmd(input logic [MODE_W-1:0] m, input logic [NODE_PORT_W-1:0] nd,
                          input logic [SLOT_PORT_W-1:0] sl, input logic [ELEM_W-1:0] v,
                          input logic lst, input bit dr);
    cmd_t c;
    c.mode  = m;
    c.node  = nd;
    c.slot  = sl;
    c.value = v;
    c.last  = lst;
    c.drain = dr;
    cmd_q.push_back(c);
    if (m != MODE_UNUSED) n_items++;
    if (m == MODE_FACE && lst) n_faces++;
  endtask

  function automatic logic [ELEM_W-1:0] pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 70) return ELEM_W'($urandom_range(6));
    if (r < 90) return ELEM_W'($urandom_range(16, 7));
    return ELEM_W'($urandom);
  endfunction

  function automatic logic [NODE_PORT_W-1:0] pool_node();
    return pool[$urandom_range(pool.size() - 1)];
  endfunction

  // A full list load: the count first, then every slot below it, so the node
  // is searchable again before any face transaction can follow.
  task automatic load_list(input logic [NODE_PORT_W-1:0] nd, input logic [ELEM_W-1:0] cnt,
                           input bit with_shared, input logic [ELEM_W-1:0] shared);
    int len, pos, s;
    logic [ELEM_W-1:0] e;
    len = (cnt > SLOTS) ? SLOTS : int'(cnt);
    pos = (len > 0) ? $urandom_range(len - 1) : 0;
    push_cmd(MODE_COUNT, nd, SLOT_PORT_W'($urandom), cnt, 1'($urandom), 1'b0);
    for (s = 0; s < len; s++) begin
      if (with_shared && s == pos) e = shared;
      else if ($urandom_range(99) < 12) e = ELEM_W'($urandom);
      else e = elem_pool[$urandom_range(7)];
      push_cmd(MODE_ENTRY, nd, SLOT_PORT_W'(s), e, 1'($urandom), 1'b0);
    end
  endtask

  always @(posedge clk) begin : cmd_driver
    bit   taken;
    cmd_t nxt;
    taken = start && !busy;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (taken) begin
        apply_cmd(cur_cmd);
        n_accepted++;
      end
      if (start && !taken) begin
        // Hold the current transaction until the block takes it.
      end else if (cmd_q.size() != 0 && !(cmd_q[0].drain && owner_q.size() != 0) &&
                   $urandom_range(99) >= ((n_accepted >= 500 && n_accepted < 800) ? 0 : 31)) begin
        nxt = cmd_q.pop_front();
        cur_cmd   = nxt;
        start     <= 1'b1;
        mode      <= nxt.mode;
        node      <= nxt.node;
        slot      <= nxt.slot;
        value     <= nxt.value;
        last_node <= nxt.last;
      end else begin
        start     <= 1'b0;
        mode      <= MODE_W'($urandom);
        node      <= NODE_PORT_W'($urandom);
        slot      <= SLOT_PORT_W'($urandom);
        value     <= ELEM_W'($urandom);
        last_node <= 1'($urandom);
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    owner_t want;
    if (!rst && done) begin
      if (owner_q.size() == 0) begin
        $display("%0t: unexpected result, element %h found %b", $time, element, found);
        failed = 1'b1;
      end else begin
        want = owner_q.pop_front();
        if (want.element !== element) begin
          $display("%0t: element expected %h actual %h", $time, want.element, element);
          failed = 1'b1;
        end
        if (want.found !== found) begin
          $display("%0t: found expected %b actual %b", $time, want.found, found);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    #(100_000_000);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int i, k, r, s;
    bit hit, drained_once;
    logic [ELEM_W-1:0]      shared;
    logic [NODE_PORT_W-1:0] nd;
    logic [NODE_PORT_W-1:0] fnode [0:5];

    drained_once = 1'b0;
    elem_pool[0] = 16'h0000;
    elem_pool[1] = 16'hFFFF;
    for (i = 2; i < 8; i++) elem_pool[i] = ELEM_W'($urandom);

    // Directed: a saturated full list on node 0 that matches only in its last
    // slot, a one-entry list on node 1 and an empty list on node 4095.
    push_cmd(MODE_COUNT, 12'd0, 4'd0, 16'hFFFF, 1'b0, 1'b0);
    for (s = 0; s < SLOTS; s++)
      push_cmd(MODE_ENTRY, 12'd0, SLOT_PORT_W'(s), (s == SLOTS - 1) ? 16'hFFFF : 16'h0000,
               1'b0, 1'b0);
    push_cmd(MODE_COUNT, 12'd1, 4'd0, 16'd1, 1'b0, 1'b0);
    push_cmd(MODE_ENTRY, 12'd1, 4'd0, 16'hFFFF, 1'b0, 1'b0);
    push_cmd(MODE_COUNT, 12'd4095, 4'd15, 16'd0, 1'b0, 1'b0);
    push_cmd(MODE_FACE, 12'd0, 4'd0, 16'd0, 1'b1, 1'b0);
    push_cmd(MODE_FACE, 12'd0, 4'd0, 16'd0, 1'b0, 1'b0);
    push_cmd(MODE_FACE, 12'd1, 4'd0, 16'd0, 1'b1, 1'b0);
    push_cmd(MODE_FACE, 12'd4095, 4'hF, 16'hFFFF, 1'b1, 1'b0);
    push_cmd(MODE_UNUSED, 12'd4095, 4'hF, 16'hFFFF, 1'b1, 1'b0);
    // Five face nodes: the fifth carries last and is dropped but still searches.
    for (i = 0; i < 4; i++) push_cmd(MODE_FACE, 12'd1, 4'd0, 16'd0, 1'b0, 1'b0);
    push_cmd(MODE_FACE, 12'd0, 4'd0, 16'd0, 1'b1, 1'b0);

    pool.push_back(12'd0);
    pool.push_back(12'd1);
    pool.push_back(12'd4095);
    in_pool[0]    = 1'b1;
    in_pool[1]    = 1'b1;
    in_pool[4095] = 1'b1;
    while (pool.size() < 23) begin
      nd = NODE_PORT_W'($urandom);
      if (!in_pool[nd]) begin
        in_pool[nd] = 1'b1;
        pool.push_back(nd);
        load_list(nd, pick_len(), 1'b0, '0);
      end
    end

    // Random part: mostly complete faces over loaded nodes, with reloads,
    // unfinished faces and stray transactions mixed in.
    while (n_items < 1350 || n_faces < 60) begin
      r = $urandom_range(99);
      if (r < 12) begin
        load_list(pool_node(), pick_len(), 1'b0, '0);
      end else if (r < 20) begin
        case ($urandom_range(2))
          0: push_cmd(MODE_UNUSED, NODE_PORT_W'($urandom), SLOT_PORT_W'($urandom),
                      ELEM_W'($urandom), 1'($urandom), 1'b0);
          1: push_cmd(MODE_ENTRY, NODE_PORT_W'($urandom), SLOT_PORT_W'($urandom),
                      ELEM_W'($urandom), 1'($urandom), 1'b0);
          default: begin
            // Counts outside the pool only, so every searched node stays loaded.
            do nd = NODE_PORT_W'($urandom); while (in_pool[nd]);
            push_cmd(MODE_COUNT, nd, SLOT_PORT_W'($urandom), ELEM_W'($urandom),
                     1'($urandom), 1'b0);
          end
        endcase
      end else if (r < 25) begin
        k = $urandom_range(2, 1);
        for (i = 0; i < k; i++)
          push_cmd(MODE_FACE, pool_node(), SLOT_PORT_W'($urandom), ELEM_W'($urandom),
                   1'b0, 1'b0);
      end else begin
        r = $urandom_range(99);
        if (r < 10) k = 1;
        else if (r < 80) k = $urandom_range(4, 2);
        else k = $urandom_range(6, 5);
        for (i = 0; i < k; i++) fnode[i] = pool_node();
        hit = ($urandom_range(99) < 25);
        shared = ($urandom_range(99) < 80) ? elem_pool[$urandom_range(7)] : ELEM_W'($urandom);
        if (hit)
          for (i = 0; i < k; i++) load_list(fnode[i], pick_len(), 1'b1, shared);
        for (i = 0; i < k; i++)
          push_cmd(MODE_FACE, fnode[i], SLOT_PORT_W'($urandom), ELEM_W'($urandom),
                   i == k - 1, (i == 0) && (!drained_once || $urandom_range(99) < 3));
        drained_once = 1'b1;
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (cmd_q.size() != 0 || start) @(posedge clk);
    while (owner_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (!failed) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
